### sv/ddwp_pkg.sv
// ----------------------------------------------------------------------------
// ddwp_pkg: shared types and constants for the waypoint PID controller
// Angle constants, CORDIC arctangent table and the sequencer state type.
// ----------------------------------------------------------------------------
package ddwp_pkg;

    localparam int POSITION_WIDTH_DEF = 16;
    localparam int ANGLE_WIDTH_DEF    = 16;
    localparam int CORDIC_STEPS_DEF   = 16;

    localparam logic signed [17:0] ANG_PI      = 18'sd25736;
    localparam logic signed [17:0] ANG_TWO_PI  = 18'sd51472;
    localparam logic signed [17:0] ANG_HALF_PI = 18'sd12868;
    localparam logic [16:0]        DIST_MAX    = 17'd131071;

    localparam logic [2:0] CFG_TURN_P  = 3'd0;
    localparam logic [2:0] CFG_TURN_D  = 3'd1;
    localparam logic [2:0] CFG_TURN_I  = 3'd2;
    localparam logic [2:0] CFG_SPEED_P = 3'd3;
    localparam logic [2:0] CFG_SPEED_D = 3'd4;
    localparam logic [2:0] CFG_SPEED_I = 3'd5;
    localparam logic [2:0] CFG_BASE    = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_ITER,
        ST_ANGLE,
        ST_MUL,
        ST_SUM,
        ST_DRIVE,
        ST_OUT
    } state_t;

    function automatic logic signed [17:0] atan_entry(input logic [4:0] i);
        logic signed [17:0] r;
        case (i)
            5'd0:    r = 18'sd6434;
            5'd1:    r = 18'sd3798;
            5'd2:    r = 18'sd2007;
            5'd3:    r = 18'sd1019;
            5'd4:    r = 18'sd511;
            5'd5:    r = 18'sd256;
            5'd6:    r = 18'sd128;
            5'd7:    r = 18'sd64;
            5'd8:    r = 18'sd32;
            5'd9:    r = 18'sd16;
            5'd10:   r = 18'sd8;
            5'd11:   r = 18'sd4;
            5'd12:   r = 18'sd2;
            5'd13:   r = 18'sd1;
            default: r = 18'sd0;
        endcase
        return r;
    endfunction

endpackage

### sv/differential_drive_waypoint_pid.sv
// ----------------------------------------------------------------------------
// differential_drive_waypoint_pid: heading and distance PID for a two-wheel base
// Distance by bit-serial root, heading by iterative CORDIC, then two PIDs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one control tick: position,
//   waypoint and measured heading. Output channel (out_valid/out_stall)
//   returns left/right drive, distance and wrapped heading error.
//   One tick is worked at a time. The result is valid once the distance
//   root (one bit per cycle, run alongside the CORDIC) and the CORDIC
//   iteration loop have both finished, followed by the angle, integral,
//   product and drive steps. The six PID products go through one
//   16x34 multiplier, one per cycle. A new tick is taken only after the
//   result has been transferred out and the block is back in idle.
//   The result sits in output registers; while the receiver stalls it is
//   held and the input stays stalled. At reset the gains take their default
//   values and all PID history (last errors, integrals) is cleared.
//   Configuration writes are taken at any time; write only while idle.
// ----------------------------------------------------------------------------
module differential_drive_waypoint_pid #(
    parameter int POSITION_WIDTH = ddwp_pkg::POSITION_WIDTH_DEF,
    parameter int ANGLE_WIDTH    = ddwp_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STEPS   = ddwp_pkg::CORDIC_STEPS_DEF
)(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [2:0]                       cfg_index,
    input  logic [15:0]                      cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [POSITION_WIDTH-1:0] pos_x,
    input  logic signed [POSITION_WIDTH-1:0] pos_y,
    input  logic signed [POSITION_WIDTH-1:0] goal_x,
    input  logic signed [POSITION_WIDTH-1:0] goal_y,
    input  logic signed [ANGLE_WIDTH-1:0]    heading,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [15:0]               left_drive,
    output logic signed [15:0]               right_drive,
    output logic [16:0]                      distance_error,
    output logic signed [15:0]               heading_error
);
    // offset width and CORDIC datapath width (offset scaled by 256 plus growth)
    localparam int DW = POSITION_WIDTH + 1;
    localparam int CWD = DW + 8 + 3;
    localparam int SW = 2 * DW + 2;
    localparam int SQW = SW / 2;
    localparam int IW = $clog2(CORDIC_STEPS + 1);
    localparam int AW = ANGLE_WIDTH + 2;

    ddwp_pkg::state_t state_reg, state_next;

    logic signed [15:0] kp_t_reg, kd_t_reg, ki_t_reg;
    logic signed [15:0] kp_s_reg, kd_s_reg, ki_s_reg, base_reg;

    logic signed [DW-1:0]  dx_reg, dy_reg;
    logic signed [AW-1:0]  hd_reg;
    logic signed [CWD-1:0] cx_reg, cy_reg;
    logic signed [17:0]    z_reg;
    logic [IW-1:0]         it_reg;
    logic                  zero_reg;
    logic                  sq_done_reg;
    logic [16:0]           dist_reg;
    logic signed [17:0]    herr_reg;
    logic [16:0]           last_d_reg;
    logic signed [17:0]    last_e_reg;
    logic signed [31:0]    dsum_reg, esum_reg;
    logic [2:0]            mi_reg;
    logic signed [53:0]    sacc_reg, tacc_reg;
    logic signed [37:0]    spd_reg, trn_reg;
    logic                  out_valid_reg;

    // distance root
    logic            sq_start, sq_done;
    logic [SQW-1:0]  sq_root;
    logic [SW-1:0]   sq_in;
    logic signed [2*DW-1:0] dx2, dy2;

    assign dx2 = dx_reg * dx_reg;
    assign dy2 = dy_reg * dy_reg;
    assign sq_in = SW'(unsigned'(dx2)) + SW'(unsigned'(dy2));

    ddwp_sqrt #(.RW(SW)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_in),
        .done     (sq_done),
        .root     (sq_root)
    );

    // offsets beyond the distance range saturate the distance outright
    localparam logic signed [33:0] DIST_MAX_S = 34'sd131071;
    logic dx_big, dy_big;
    always_comb
    begin
        dx_big = ((dx_reg < 0) ? -34'(dx_reg) : 34'(dx_reg)) > 34'(DIST_MAX_S);
        dy_big = ((dy_reg < 0) ? -34'(dy_reg) : 34'(dy_reg)) > 34'(DIST_MAX_S);
    end

    logic accept_in;
    assign accept_in = in_valid && !in_stall;
    assign in_stall  = (state_reg != ddwp_pkg::ST_IDLE);
    assign sq_start  = (state_reg == ddwp_pkg::ST_PREP);

    // wrap into +-pi once
    function automatic logic signed [18:0] wrap1(input logic signed [18:0] a);
        logic signed [18:0] r;
        r = a;
        if (a > 19'(ddwp_pkg::ANG_PI))
            r = a - 19'(ddwp_pkg::ANG_TWO_PI);
        else if (a < -19'(ddwp_pkg::ANG_PI))
            r = a + 19'(ddwp_pkg::ANG_TWO_PI);
        return r;
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ddwp_pkg::ST_IDLE:  if (accept_in) state_next = ddwp_pkg::ST_PREP;
            ddwp_pkg::ST_PREP:  state_next = ddwp_pkg::ST_ITER;
            ddwp_pkg::ST_ITER:
                if (it_reg == IW'(CORDIC_STEPS) && (sq_done_reg || sq_done))
                    state_next = ddwp_pkg::ST_ANGLE;
            ddwp_pkg::ST_ANGLE: state_next = ddwp_pkg::ST_SUM;
            ddwp_pkg::ST_SUM:   state_next = ddwp_pkg::ST_MUL;
            ddwp_pkg::ST_MUL:   if (mi_reg == 3'd5) state_next = ddwp_pkg::ST_DRIVE;
            ddwp_pkg::ST_DRIVE: state_next = ddwp_pkg::ST_OUT;
            ddwp_pkg::ST_OUT:   if (!out_stall) state_next = ddwp_pkg::ST_IDLE;
            default:            state_next = ddwp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ddwp_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_t_reg <= -16'sd2560;
            kd_t_reg <= 16'sd26;
            ki_t_reg <= -16'sd13;
            kp_s_reg <= '0;
            kd_s_reg <= '0;
            ki_s_reg <= '0;
            base_reg <= 16'sd1280;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ddwp_pkg::CFG_TURN_P:  kp_t_reg <= cfg_data;
                ddwp_pkg::CFG_TURN_D:  kd_t_reg <= cfg_data;
                ddwp_pkg::CFG_TURN_I:  ki_t_reg <= cfg_data;
                ddwp_pkg::CFG_SPEED_P: kp_s_reg <= cfg_data;
                ddwp_pkg::CFG_SPEED_D: kd_s_reg <= cfg_data;
                ddwp_pkg::CFG_SPEED_I: ki_s_reg <= cfg_data;
                ddwp_pkg::CFG_BASE:    base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // CORDIC step operands
    logic signed [CWD-1:0] xs, ys;
    logic [4:0] it5;
    assign it5 = 5'(it_reg);
    assign xs = cx_reg >>> it_reg;
    assign ys = cy_reg >>> it_reg;

    // angle and error
    logic signed [18:0] zc, tgt, hw, herr_w;
    always_comb
    begin
        zc = 19'(z_reg);
        if (zc > 19'(ddwp_pkg::ANG_PI)) zc = 19'(ddwp_pkg::ANG_PI);
        if (zc < -19'(ddwp_pkg::ANG_PI)) zc = -19'(ddwp_pkg::ANG_PI);
        if (zero_reg) zc = '0;
        tgt    = wrap1(wrap1(-zc));
        hw     = wrap1(19'(hd_reg));
        herr_w = wrap1(tgt - hw);
    end

    // shared multiplier: one gain by one operand per cycle
    logic signed [15:0] mgain;
    logic signed [33:0] mop;
    logic signed [49:0] mprod;
    always_comb
    begin
        case (mi_reg)
            3'd0:    begin mgain = kp_s_reg; mop = 34'(signed'({1'b0, dist_reg})); end
            3'd1:    begin mgain = kd_s_reg;
                           mop = 34'(signed'({1'b0, dist_reg})) - 34'(signed'({1'b0, last_d_reg}));
                     end
            3'd2:    begin mgain = ki_s_reg; mop = 34'(dsum_reg); end
            3'd3:    begin mgain = kp_t_reg; mop = 34'(herr_reg); end
            3'd4:    begin mgain = kd_t_reg; mop = 34'(herr_reg) - 34'(last_e_reg); end
            default: begin mgain = ki_t_reg; mop = 34'(esum_reg); end
        endcase
        mprod = mgain * mop;
    end

    // saturating integral updates
    logic signed [33:0] dsum_w, esum_w;
    assign dsum_w = 34'(dsum_reg) + 34'(signed'({1'b0, dist_reg}));
    assign esum_w = 34'(esum_reg) + 34'(herr_reg);

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh7fffffff)       r = 32'sh7fffffff;
        else if (v < -34'sh80000000) r = -32'sh80000000;
        else                         r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [38:0] v);
        logic signed [15:0] r;
        if (v > 39'sd32767)       r = 16'sh7fff;
        else if (v < -39'sd32768) r = -16'sh8000;
        else                      r = v[15:0];
        return r;
    endfunction

    logic signed [53:0] sr, tr;
    logic signed [38:0] lsum, rsum;
    assign sr = (sacc_reg + 54'sd2048) >>> 12;
    assign tr = (tacc_reg + 54'sd4096) >>> 13;
    assign lsum = 39'(spd_reg) + 39'(trn_reg);
    assign rsum = 39'(spd_reg) - 39'(trn_reg);

    // datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_d_reg  <= '0;
            last_e_reg  <= '0;
            dsum_reg    <= '0;
            esum_reg    <= '0;
            sq_done_reg <= 1'b0;
            it_reg      <= '0;
            mi_reg      <= '0;
            dx_reg      <= '0;
            dy_reg      <= '0;
            hd_reg      <= '0;
            cx_reg      <= '0;
            cy_reg      <= '0;
            z_reg       <= '0;
            zero_reg    <= 1'b0;
            dist_reg    <= '0;
            herr_reg    <= '0;
            sacc_reg    <= '0;
            tacc_reg    <= '0;
            spd_reg     <= '0;
            trn_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                ddwp_pkg::ST_IDLE:
                    if (accept_in)
                    begin
                        dx_reg <= DW'(goal_x) - DW'(pos_x);
                        dy_reg <= DW'(goal_y) - DW'(pos_y);
                        hd_reg <= AW'(heading);
                    end
                ddwp_pkg::ST_PREP:
                begin
                    sq_done_reg <= 1'b0;
                    it_reg      <= '0;
                    zero_reg    <= (dx_reg == 0) && (dy_reg == 0);
                    if (dx_reg < 0)
                    begin
                        if (dy_reg >= 0)
                        begin
                            cx_reg <= CWD'(dy_reg) <<< 8;
                            cy_reg <= -(CWD'(dx_reg) <<< 8);
                            z_reg  <= ddwp_pkg::ANG_HALF_PI;
                        end
                        else
                        begin
                            cx_reg <= -(CWD'(dy_reg) <<< 8);
                            cy_reg <= CWD'(dx_reg) <<< 8;
                            z_reg  <= -ddwp_pkg::ANG_HALF_PI;
                        end
                    end
                    else
                    begin
                        cx_reg <= CWD'(dx_reg) <<< 8;
                        cy_reg <= CWD'(dy_reg) <<< 8;
                        z_reg  <= '0;
                    end
                end
                ddwp_pkg::ST_ITER:
                begin
                    if (sq_done)
                    begin
                        sq_done_reg <= 1'b1;
                        if (dx_big || dy_big || (SQW'(sq_root) > SQW'(DIST_MAX_S)))
                            dist_reg <= ddwp_pkg::DIST_MAX;
                        else
                            dist_reg <= 17'(sq_root);
                    end
                    if (it_reg != IW'(CORDIC_STEPS))
                    begin
                        it_reg <= it_reg + 1'b1;
                        if (cy_reg > 0)
                        begin
                            cx_reg <= cx_reg + ys;
                            cy_reg <= cy_reg - xs;
                            z_reg  <= z_reg + ddwp_pkg::atan_entry(it5);
                        end
                        else
                        begin
                            cx_reg <= cx_reg - ys;
                            cy_reg <= cy_reg + xs;
                            z_reg  <= z_reg - ddwp_pkg::atan_entry(it5);
                        end
                    end
                end
                ddwp_pkg::ST_ANGLE:
                    herr_reg <= 18'(herr_w);
                ddwp_pkg::ST_SUM:
                begin
                    dsum_reg <= sat32(dsum_w);
                    esum_reg <= sat32(esum_w);
                    mi_reg   <= '0;
                    sacc_reg <= '0;
                    tacc_reg <= '0;
                end
                ddwp_pkg::ST_MUL:
                begin
                    mi_reg <= mi_reg + 1'b1;
                    if (mi_reg < 3'd3)
                        sacc_reg <= sacc_reg + 54'(mprod);
                    else
                        tacc_reg <= tacc_reg + 54'(mprod);
                end
                ddwp_pkg::ST_DRIVE:
                begin
                    // keep the full terms; only the final drives saturate
                    spd_reg    <= 38'(base_reg) + 38'(sr);
                    trn_reg    <= 38'(tr);
                    last_d_reg <= dist_reg;
                    last_e_reg <= herr_reg;
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= (state_next == ddwp_pkg::ST_OUT);
    end

    assign out_valid      = out_valid_reg && (state_reg == ddwp_pkg::ST_OUT);
    assign left_drive     = sat16(lsum);
    assign right_drive    = sat16(rsum);
    assign distance_error = dist_reg;
    assign heading_error  = herr_reg[15:0];
endmodule

### sv/ddwp_sqrt.sv
// ----------------------------------------------------------------------------
// ddwp_sqrt: digit-serial integer square root
// Restoring root, one result bit (two radicand bits) per cycle.
// ----------------------------------------------------------------------------
module ddwp_sqrt #(
    parameter int RW = 36
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [RW-1:0] radicand,
    output logic          done,
    output logic [RW/2-1:0] root
);
    localparam int HW = RW / 2;
    localparam int CW = $clog2(HW + 1);

    logic [RW-1:0]  rad_reg, rad_next;
    logic [HW+1:0]  rem_reg, rem_next;
    logic [HW-1:0]  root_reg, root_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic [HW+1:0]  trial;
    logic [HW+1:0]  shifted;

    always_comb
    begin
        shifted   = {rem_reg[HW-1:0], rad_reg[RW-1:RW-2]};
        trial     = {root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CW'(HW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[RW-3:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next  = shifted - trial;
                root_next = {root_reg[HW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                root_next = {root_reg[HW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = busy_reg && (cnt_reg == CW'(1));
    assign root = root_next;
endmodule
